// ===== design/rlpce_pkg.sv =====
// shared types and constants for the rgb led pulse-code encoder
// no dependencies; imported by every module of the block
package rlpce_pkg;

    localparam int ByteW    = 8;
    localparam int NumLanes = 3;
    localparam int LedSlots = NumLanes * ByteW;
    localparam int SlotW    = 5;
    localparam int AddrW    = 4;

    localparam logic [SlotW-1:0] LastSlot = SlotW'(LedSlots - 1);

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] RegBrightness = 2'd0;
    localparam logic [1:0] RegFullScale  = 2'd1;
    localparam logic [1:0] RegOneCode    = 2'd2;
    localparam logic [1:0] RegZeroCode   = 2'd3;

    typedef struct packed {
        logic [ByteW-1:0] brightness;
        logic [ByteW-1:0] full_scale;
        logic [ByteW-1:0] one_code;
        logic [ByteW-1:0] zero_code;
    } cfg_t;

    typedef struct packed {
        logic idle;
        logic done;
    } lane_status_t;

endpackage

// ===== design/rlpce_lane.sv =====
// one colour lane: multiply by brightness, then divide by full_scale with saturation
// depends on rlpce_pkg
module rlpce_lane
    import rlpce_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             take,
    input  logic [ByteW-1:0] value,
    input  cfg_t             cfg,
    output lane_status_t     status,
    output logic [ByteW-1:0] result
);

    typedef enum logic [3:0] {
        LS_IDLE  = 4'b0001,
        LS_CHECK = 4'b0010,
        LS_DIV   = 4'b0100,
        LS_HOLD  = 4'b1000
    } lane_state_t;

    lane_state_t          state_reg, state_next;
    logic [2:0]           iter_reg, iter_next;
    logic [2*ByteW-1:0]   prod_reg;
    logic [ByteW-1:0]     rem_reg, rem_next;
    logic [ByteW-1:0]     quo_reg, quo_next;
    logic [ByteW:0]       trial;
    logic [ByteW:0]       diff;
    logic                 ge;

    // one restoring step: shift in the next numerator bit and try the divisor
    assign trial = {rem_reg, quo_reg[ByteW-1]};
    assign diff  = trial - {1'b0, cfg.full_scale};
    assign ge    = trial >= {1'b0, cfg.full_scale};

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        case (state_reg)
            LS_IDLE:
            begin
                if (start)
                begin
                    state_next = LS_CHECK;
                end
            end
            LS_CHECK:
            begin
                // quotient above one byte (or zero divisor) saturates
                if (prod_reg[2*ByteW-1:ByteW] >= cfg.full_scale)
                begin
                    quo_next   = '1;
                    state_next = LS_HOLD;
                end
                else
                begin
                    rem_next   = prod_reg[2*ByteW-1:ByteW];
                    quo_next   = prod_reg[ByteW-1:0];
                    iter_next  = '0;
                    state_next = LS_DIV;
                end
            end
            LS_DIV:
            begin
                rem_next  = ge ? diff[ByteW-1:0] : trial[ByteW-1:0];
                quo_next  = {quo_reg[ByteW-2:0], ge};
                iter_next = iter_reg + 3'd1;
                if (iter_reg == 3'd7)
                begin
                    state_next = LS_HOLD;
                end
            end
            LS_HOLD:
            begin
                if (take)
                begin
                    state_next = LS_IDLE;
                end
            end
            default:
            begin
                state_next = LS_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LS_IDLE;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == LS_IDLE && start)
        begin
            prod_reg <= value * cfg.brightness;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign status.idle = (state_reg == LS_IDLE);
    assign status.done = (state_reg == LS_HOLD);
    assign result      = quo_reg;

endmodule

// ===== design/rlpce_serializer.sv =====
// merging stage: packs the three lane bytes and sends 24 slot beats, msb first
// depends on rlpce_pkg
module rlpce_serializer
    import rlpce_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic [LedSlots-1:0] bits,
    input  cfg_t                cfg,
    output logic                load_ok,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,   // pulse_code[7:0], bit_value[8], zeros[15:9]
    output logic                m_tlast    // led_done
);

    logic                active_reg;
    logic [SlotW-1:0]    count_reg;
    logic [LedSlots-1:0] shift_reg;
    logic                beat;
    logic                last;
    logic                cur_bit;

    assign beat    = active_reg && m_tready;
    assign last    = (count_reg == LastSlot);
    assign load_ok = !active_reg || (m_tready && last);

    // slot counter and busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            count_reg  <= '0;
        end
        else if (load)
        begin
            active_reg <= 1'b1;
            count_reg  <= '0;
        end
        else if (beat && last)
        begin
            active_reg <= 1'b0;
        end
        else if (beat)
        begin
            count_reg <= count_reg + SlotW'(1);
        end
    end

    // bit shifter
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            shift_reg <= bits;
        end
        else if (beat)
        begin
            shift_reg <= {shift_reg[LedSlots-2:0], 1'b0};
        end
    end

    // output beat
    assign cur_bit  = shift_reg[LedSlots-1];
    assign m_tvalid = active_reg;
    assign m_tlast  = last;
    assign m_tdata  = {7'd0, cur_bit, cur_bit ? cfg.one_code : cfg.zero_code};

endmodule

// ===== design/rgb_led_pulse_code_encoder.sv =====
// top level of the rgb led pulse-code encoder: apb registers, three scaling lanes, serializer
// depends on rlpce_pkg, rlpce_lane and rlpce_serializer
//
//  channel  dir  handshake                  payload
//  s_axis   in   s_tvalid / s_tready        s_tdata: green[7:0], red[15:8], blue[23:16]
//  m_axis   out  m_tvalid / m_tready        m_tdata: pulse_code[7:0], bit_value[8]; m_tlast
//  apb      in   psel / penable / pready    paddr[3:0], pwdata, prdata
//
//  one colour beat gives 24 output beats, one per cycle while m_tready is high
//  each lane scales its byte by a multiply at the accepting edge, then a saturation check
//  and, unless it saturates, eight restoring divide steps; the lanes take the next colour
//  once their results are handed to the serializer, so later leds are scaled while the
//  24 slot beats of the previous led are still being sent on the m_axis channel
//  rst_n clears the registers to their defaults and empties lanes and serializer
//  a stalled output holds its beat; lanes hold their result until the serializer loads
module rgb_led_pulse_code_encoder
    import rlpce_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [23:0]      s_tdata,   // green[7:0], red[15:8], blue[23:16]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,   // pulse_code[7:0], bit_value[8], zeros[15:9]
    output logic             m_tlast,   // led_done
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    cfg_t             cfg_reg;
    logic             cfg_wr;
    logic             accept;
    logic             take;
    logic             load_ok;
    logic [NumLanes-1:0] idle_vec;
    logic [NumLanes-1:0] done_vec;
    lane_status_t     lane_st [NumLanes];
    logic [ByteW-1:0] lane_res [NumLanes];

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.brightness <= 8'd255;
            cfg_reg.full_scale <= 8'd255;
            cfg_reg.one_code   <= 8'd8;
            cfg_reg.zero_code  <= 8'd4;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                RegBrightness: cfg_reg.brightness <= pwdata[ByteW-1:0];
                RegFullScale:  cfg_reg.full_scale <= pwdata[ByteW-1:0];
                RegOneCode:    cfg_reg.one_code   <= pwdata[ByteW-1:0];
                RegZeroCode:   cfg_reg.zero_code  <= pwdata[ByteW-1:0];
                default:       ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (paddr[3:2])
            RegBrightness: prdata = {24'd0, cfg_reg.brightness};
            RegFullScale:  prdata = {24'd0, cfg_reg.full_scale};
            RegOneCode:    prdata = {24'd0, cfg_reg.one_code};
            RegZeroCode:   prdata = {24'd0, cfg_reg.zero_code};
            default:       prdata = '0;
        endcase
    end

    // scaling lanes, one per colour byte
    for (genvar i = 0; i < NumLanes; i++)
    begin : g_lane
        rlpce_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .start  (accept),
            .take   (take),
            .value  (s_tdata[i*ByteW +: ByteW]),
            .cfg    (cfg_reg),
            .status (lane_st[i]),
            .result (lane_res[i])
        );
        assign idle_vec[i] = lane_st[i].idle;
        assign done_vec[i] = lane_st[i].done;
    end

    // input handshake and hand-over to the serializer
    assign s_tready = &idle_vec;
    assign accept   = s_tvalid && s_tready;
    assign take     = (&done_vec) && load_ok;

    rlpce_serializer u_ser (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (take),
        .bits     ({lane_res[0], lane_res[1], lane_res[2]}),
        .cfg      (cfg_reg),
        .load_ok  (load_ok),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // lanes leave and return to idle together
    a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        idle_vec == '0 || idle_vec == '1)
        else $error("scaling lanes out of step");

    // an accepted colour leaves the lanes busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("lanes idle after accepting a colour");

    // a hand-over always presents a beat next cycle
    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> m_tvalid && !m_tlast)
        else $error("no first slot beat after hand-over");

    // after the final slot with nothing handed over, output goes quiet
    a_last_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast && !take) |=> !m_tvalid)
        else $error("beat presented without a loaded led");

endmodule

// ===== verif/rgb_led_pulse_code_encoder_checker.sv =====
`timescale 1ns / 1ps
// checker for the rgb led pulse-code encoder: watches apb, colour and slot channels,
// predicts the 24 slot beats of every colour and compares them; depends on rlpce_pkg
module rgb_led_pulse_code_encoder_checker
    import rlpce_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [23:0]      s_tdata,   // green[7:0], red[15:8], blue[23:16]
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [15:0]      m_tdata,   // pulse_code[7:0], bit_value[8], zeros[15:9]
    input  logic             m_tlast,   // led_done
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [31:0]      pwdata,
    input  logic [31:0]      prdata,
    input  logic             pready,
    output int               failures,
    output int               pending,
    output int               leds_seen,
    output int               slots_seen
);

    typedef struct packed {
        logic [ByteW-1:0] pulse_code;
        logic             bit_value;
        logic             led_done;
    } slot_t;

    cfg_t  levels;
    slot_t slot_q[$];

    // colour byte times brightness over full scale, truncated and clipped to a byte
    function automatic logic [ByteW-1:0] dim_byte(logic [ByteW-1:0] v, cfg_t c);
        logic [15:0] product;
        logic [15:0] quotient;
        product = 16'(v) * 16'(c.brightness);
        if (c.full_scale == '0)
            return 8'hFF;
        quotient = product / 16'(c.full_scale);
        return (quotient > 16'd255) ? 8'hFF : quotient[7:0];
    endfunction

    // queue the slot beats of one led, green msb first, blue lsb last
    task automatic queue_led_slots(logic [23:0] colour);
        logic [LedSlots-1:0] bits;
        slot_t               s;
        bits = {dim_byte(colour[7:0], levels), dim_byte(colour[15:8], levels),
                dim_byte(colour[23:16], levels)};
        for (int k = LedSlots - 1; k >= 0; k--)
        begin
            s.bit_value  = bits[k];
            s.pulse_code = bits[k] ? levels.one_code : levels.zero_code;
            s.led_done   = (k == 0);
            slot_q.push_back(s);
        end
    endtask

    task automatic report_mismatch(string what);
        $display("%0t ns  mismatch: %s", $time, what);
        failures++;
    endtask

    function automatic logic [ByteW-1:0] level_at(logic [1:0] idx);
        case (idx)
            RegBrightness: return levels.brightness;
            RegFullScale:  return levels.full_scale;
            RegOneCode:    return levels.one_code;
            default:       return levels.zero_code;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        slot_t exp_slot;
        if (!rst_n)
        begin
            levels     = '{brightness: 8'd255, full_scale: 8'd255,
                           one_code: 8'd8, zero_code: 8'd4};
            slot_q.delete();
            failures   = 0;
            leds_seen  = 0;
            slots_seen = 0;
            pending   <= 0;
        end
        else
        begin
            // register access phase
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (paddr[3:2])
                        RegBrightness: levels.brightness = pwdata[7:0];
                        RegFullScale:  levels.full_scale = pwdata[7:0];
                        RegOneCode:    levels.one_code   = pwdata[7:0];
                        default:       levels.zero_code  = pwdata[7:0];
                    endcase
                end
                else if (prdata !== {24'd0, level_at(paddr[3:2])})
                    report_mismatch($sformatf("register %0d read %h, expected %h",
                                    paddr[3:2], prdata, level_at(paddr[3:2])));
            end

            // slot beat against the oldest expectation
            if (m_tvalid === 1'b1 && m_tready === 1'b1)
            begin
                slots_seen++;
                if (slot_q.size() == 0)
                    report_mismatch($sformatf("slot beat %h/%b with nothing expected",
                                    m_tdata, m_tlast));
                else
                begin
                    exp_slot = slot_q.pop_front();
                    if (m_tdata[7:0] !== exp_slot.pulse_code)
                        report_mismatch($sformatf("pulse_code %h, expected %h",
                                        m_tdata[7:0], exp_slot.pulse_code));
                    if (m_tdata[8] !== exp_slot.bit_value)
                        report_mismatch($sformatf("bit_value %b, expected %b",
                                        m_tdata[8], exp_slot.bit_value));
                    if (m_tlast !== exp_slot.led_done)
                        report_mismatch($sformatf("led_done %b, expected %b",
                                        m_tlast, exp_slot.led_done));
                    if (m_tdata[15:9] !== 7'd0)
                        report_mismatch($sformatf("padding bits %h not zero",
                                        m_tdata[15:9]));
                end
            end

            // colour beat
            if (s_tvalid === 1'b1 && s_tready === 1'b1)
            begin
                leds_seen++;
                queue_led_slots(s_tdata);
            end

            pending <= slot_q.size();
        end
    end

endmodule

// ===== verif/rgb_led_pulse_code_encoder_test.sv =====
`timescale 1ns / 1ps
// testbench top for the rgb led pulse-code encoder: clock, reset, apb and colour stimulus,
// slot back-pressure and verdict; depends on rlpce_pkg and rgb_led_pulse_code_encoder_checker
module rgb_led_pulse_code_encoder_test
    import rlpce_pkg::*;
;

    localparam int CycleLimit = 1000000;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [23:0]      s_tdata;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [15:0]      m_tdata;
    logic             m_tlast;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [AddrW-1:0] paddr;
    logic [31:0]      pwdata;
    logic [31:0]      prdata;
    logic             pready;

    int failures;
    int pending;
    int leds_seen;
    int slots_seen;
    int cycles = 0;
    int settings_used = 0;
    bit calm = 1'b0;
    int stall_left = 0;
    int ready_left = 0;

    rgb_led_pulse_code_encoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    rgb_led_pulse_code_encoder_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .failures   (failures),
        .pending    (pending),
        .leds_seen  (leds_seen),
        .slots_seen (slots_seen)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CycleLimit)
        begin
            $display("timed out after %0d cycles with %0d slot beats pending", cycles, pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // slot back-pressure: random stall bursts between ready stretches
    always @(posedge clk)
    begin
        if (calm)
            m_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (ready_left > 0)
        begin
            ready_left--;
            m_tready <= 1'b1;
        end
        else
        begin
            ready_left = $urandom_range(1, 60);
            stall_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 18) : 0;
            m_tready <= 1'b1;
        end
    end

    // every task starts and ends just after a rising edge
    task automatic apb_access(bit wr, logic [1:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic read_levels();
        apb_access(1'b0, RegBrightness, '0);
        apb_access(1'b0, RegFullScale, '0);
        apb_access(1'b0, RegOneCode, '0);
        apb_access(1'b0, RegZeroCode, '0);
    endtask

    // only while idle: upper data bits are junk and must be dropped
    task automatic set_levels(logic [7:0] bright, logic [7:0] fscale,
                              logic [7:0] one_c, logic [7:0] zero_c);
        apb_access(1'b1, RegBrightness, {24'($urandom_range(0, 16777215)), bright});
        apb_access(1'b1, RegFullScale, {24'($urandom_range(0, 16777215)), fscale});
        apb_access(1'b1, RegOneCode, {24'($urandom_range(0, 16777215)), one_c});
        apb_access(1'b1, RegZeroCode, {24'($urandom_range(0, 16777215)), zero_c});
        read_levels();
        settings_used++;
    endtask

    // one colour beat, with an optional gap before it
    task automatic send_colour(logic [7:0] green, logic [7:0] red, logic [7:0] blue);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {blue, red, green};
        @(negedge clk);
        while (!s_tready) @(negedge clk);
        @(posedge clk);
    endtask

    // hold the colour side until every slot beat has come out
    task automatic drain_slots();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h01 << $urandom_range(0, 7);
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_scale();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1, 2:    return 8'd255;
            3:       return 8'd1;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values, unit scaling
        read_levels();
        send_colour(8'h00, 8'h00, 8'h00);
        send_colour(8'hFF, 8'hFF, 8'hFF);
        send_colour(8'hAA, 8'h55, 8'h0F);
        send_colour(8'h80, 8'h01, 8'hFE);
        send_colour(8'h7F, 8'h00, 8'hFF);
        drain_slots();

        // full scale of one: everything non-zero comes out as all ones
        set_levels(8'd255, 8'd1, 8'd8, 8'd4);
        send_colour(8'h01, 8'h00, 8'h02);
        send_colour(8'hFF, 8'h80, 8'h00);
        send_colour(8'h00, 8'h01, 8'h00);
        drain_slots();

        // zero full scale: divider gives all ones
        set_levels(8'd100, 8'd0, 8'd200, 8'd3);
        send_colour(8'h00, 8'h00, 8'h00);
        send_colour(8'h12, 8'h34, 8'h56);
        drain_slots();

        // zero brightness, extreme codes
        set_levels(8'd0, 8'd255, 8'd255, 8'd0);
        send_colour(8'hFF, 8'hFF, 8'hFF);
        send_colour(8'h5A, 8'hA5, 8'h3C);
        drain_slots();

        // brightness above full scale saturates only the large bytes
        set_levels(8'd200, 8'd100, 8'd0, 8'd255);
        send_colour(8'h7F, 8'h80, 8'h81);
        send_colour(8'hFF, 8'h01, 8'h02);
        drain_slots();

        // ordinary dimming with truncation
        set_levels(8'd128, 8'd200, 8'd9, 8'd5);
        send_colour(8'hFF, 8'hC8, 8'h03);
        send_colour(8'h99, 8'h66, 8'h33);
        send_colour(8'h01, 8'hFE, 8'h10);
        drain_slots();

        // random phases, the last one without idling on either side
        for (int phase = 0; phase < 4; phase++)
        begin
            calm = (phase == 3);
            set_levels(($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 1) * 255)
                                                   : 8'($urandom_range(0, 255)),
                       pick_scale(), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            for (int n = 0; n < 36; n++)
            begin
                if (n == 18 && !calm)
                    drain_slots();
                send_colour(pick_byte(), pick_byte(), pick_byte());
            end
            drain_slots();
        end

        // settle, then look for stray slot beats
        repeat (60) @(posedge clk);
        $display("covered %0d colour beats and %0d slot beats over %0d register settings",
                 leds_seen, slots_seen, settings_used);
        $display("including saturation, zero full scale, zero brightness and back-pressure");
        if (failures == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
